### design/mexp_pkg.sv
// shared types and constants for the modular exponentiation unit
// no dependencies; used by mexp_mulmod and modular_exponentiation_unit
package mexp_pkg;

   // width of every payload field on the ports
   localparam int FIELD_WIDTH = 32;

   // default datapath width
   localparam int DATA_WIDTH_DEFAULT = 32;

   // modulus after reset
   localparam logic [FIELD_WIDTH-1:0] MODULUS_RESET = 32'd12289;

   // top-level sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_WAIT,
      ST_FINISH
   } seq_state_type;

   // modular multiply unit states
   typedef enum logic [1:0] {
      MM_IDLE,
      MM_MULT,
      MM_REDUCE
   } mm_state_type;

endpackage

### design/mexp_mulmod.sv
// shared modular multiplier: one product, then a bit-serial remainder
// depends on mexp_pkg
module mexp_mulmod #(
   parameter int DATA_WIDTH = mexp_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] operand_a,
   input  logic [DATA_WIDTH-1:0] operand_b,
   input  logic [DATA_WIDTH-1:0] modulus,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] result
);

   localparam int PROD_WIDTH = 2 * DATA_WIDTH;
   localparam int CNT_WIDTH  = $clog2(PROD_WIDTH);

   mexp_pkg::mm_state_type state_ff, state_in;

   logic [DATA_WIDTH-1:0] opa_ff, opa_in;
   logic [DATA_WIDTH-1:0] opb_ff, opb_in;
   logic [PROD_WIDTH-1:0] prod_ff, prod_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;

   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH:0]   mod_ext;
   logic [DATA_WIDTH:0]   diff;
   logic [DATA_WIDTH-1:0] rem_step;

   // one restoring remainder step: shift in the next product bit
   always_comb begin
      shifted  = {rem_ff, prod_ff[PROD_WIDTH-1]};
      mod_ext  = {1'b0, modulus};
      diff     = shifted - mod_ext;
      rem_step = (shifted >= mod_ext) ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
   end

   // sequencer for multiply and reduce
   always_comb begin
      state_in = state_ff;
      opa_in   = opa_ff;
      opb_in   = opb_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      done     = 1'b0;
      result   = rem_step;
      case (state_ff)
         mexp_pkg::MM_IDLE: begin
            if (start) begin
               opa_in   = operand_a;
               opb_in   = operand_b;
               state_in = mexp_pkg::MM_MULT;
            end
         end
         mexp_pkg::MM_MULT: begin
            prod_in  = {{DATA_WIDTH{1'b0}}, opa_ff} * {{DATA_WIDTH{1'b0}}, opb_ff};
            rem_in   = '0;
            cnt_in   = '0;
            state_in = mexp_pkg::MM_REDUCE;
         end
         mexp_pkg::MM_REDUCE: begin
            if (modulus == '0) begin
               // zero modulus keeps the low word of the product
               done     = 1'b1;
               result   = prod_ff[DATA_WIDTH-1:0];
               state_in = mexp_pkg::MM_IDLE;
            end else begin
               rem_in  = rem_step;
               prod_in = {prod_ff[PROD_WIDTH-2:0], 1'b0};
               cnt_in  = cnt_ff + 1'b1;
               if (cnt_ff == CNT_WIDTH'(PROD_WIDTH - 1)) begin
                  done     = 1'b1;
                  state_in = mexp_pkg::MM_IDLE;
               end
            end
         end
         default: begin
            state_in = mexp_pkg::MM_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mexp_pkg::MM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      opa_ff  <= opa_in;
      opb_ff  <= opb_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

endmodule

### design/modular_exponentiation_unit.sv
// modular exponentiation unit, top level: stream ports, modulus register, sequencer
// depends on mexp_pkg and mexp_mulmod
//
// Computes base_value ^ exponent mod modulus by right-to-left square-and-multiply,
// scanning the exponent from its least significant bit. Every modular multiply
// runs on one shared unit: a DATA_WIDTH x DATA_WIDTH product followed by a
// one-bit-per-cycle remainder over the double-width product (when the modulus
// is zero, the low word of the product is kept instead). An item costs one
// multiply per set exponent bit plus one squaring per exponent bit below the
// top set bit, plus the accept, final step and finish steps. An exponent of
// zero returns 1. req_tready is high only while no transaction is in progress;
// a finished result waits in the output register while the next transaction
// is accepted. The modulus is written through csr_wr_en/csr_wr_data and resets
// to 12289; the user must write it only while the block is idle, as the block
// itself does not enforce this.
module modular_exponentiation_unit #(
   parameter int DATA_WIDTH = mexp_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // input transaction
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [2*mexp_pkg::FIELD_WIDTH-1:0] req_tdata,  // base_value [31:0], exponent [63:32]
   // result transaction
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mexp_pkg::FIELD_WIDTH-1:0]   rsp_tdata,  // power_result [31:0]
   // modulus register write
   input  logic                              csr_wr_en,
   input  logic [mexp_pkg::FIELD_WIDTH-1:0]   csr_wr_data
);

   localparam int FW = mexp_pkg::FIELD_WIDTH;

   mexp_pkg::seq_state_type state_ff, state_in;

   logic [DATA_WIDTH-1:0] modulus_ff;
   logic [DATA_WIDTH-1:0] base_ff, base_in;
   logic [DATA_WIDTH-1:0] exp_ff, exp_in;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic                  target_acc_ff, target_acc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic                  mm_start;
   logic [DATA_WIDTH-1:0] mm_opa;
   logic                  mm_done;
   logic [DATA_WIDTH-1:0] mm_result;

   // shared modular multiplier
   mexp_mulmod #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_mulmod (
      .clock     (clock),
      .reset     (reset),
      .start     (mm_start),
      .operand_a (mm_opa),
      .operand_b (base_ff),
      .modulus   (modulus_ff),
      .done      (mm_done),
      .result    (mm_result)
   );

   // square-and-multiply sequencer
   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      exp_in        = exp_ff;
      acc_in        = acc_ff;
      target_acc_in = target_acc_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      req_tready    = 1'b0;
      mm_start      = 1'b0;
      mm_opa        = exp_ff[0] ? acc_ff : base_ff;
      case (state_ff)
         mexp_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               base_in  = req_tdata[DATA_WIDTH-1:0];
               exp_in   = req_tdata[FW +: DATA_WIDTH];
               acc_in   = DATA_WIDTH'(1);
               state_in = mexp_pkg::ST_STEP;
            end
         end
         mexp_pkg::ST_STEP: begin
            if (exp_ff[0]) begin
               // set bit: fold the running base into the result
               mm_start      = 1'b1;
               target_acc_in = 1'b1;
               exp_in        = {exp_ff[DATA_WIDTH-1:1], 1'b0};
               state_in      = mexp_pkg::ST_WAIT;
            end else if (exp_ff == '0) begin
               state_in = mexp_pkg::ST_FINISH;
            end else begin
               // higher bits remain: square the base and move on
               mm_start      = 1'b1;
               target_acc_in = 1'b0;
               exp_in        = {1'b0, exp_ff[DATA_WIDTH-1:1]};
               state_in      = mexp_pkg::ST_WAIT;
            end
         end
         mexp_pkg::ST_WAIT: begin
            if (mm_done) begin
               if (target_acc_ff) begin
                  acc_in = mm_result;
               end else begin
                  base_in = mm_result;
               end
               state_in = mexp_pkg::ST_STEP;
            end
         end
         mexp_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = acc_ff;
               rsp_valid_in = 1'b1;
               state_in     = mexp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mexp_pkg::ST_IDLE;
         end
      endcase
   end

   // control state and modulus register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mexp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= mexp_pkg::MODULUS_RESET[DATA_WIDTH-1:0];
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            modulus_ff <= csr_wr_data[DATA_WIDTH-1:0];
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      base_ff       <= base_in;
      exp_ff        <= exp_in;
      acc_ff        <= acc_in;
      target_acc_ff <= target_acc_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // result port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = FW'(rsp_data_ff);

endmodule

### verif/tb_modular_exponentiation_unit.sv
// self-checking testbench for modular_exponentiation_unit (stream in, stream out, modulus csr)
// depends on mexp_pkg and the design files; predicts every power in plain 64-bit arithmetic
`timescale 1ns / 100ps

module tb_modular_exponentiation_unit;

   localparam int FW = mexp_pkg::FIELD_WIDTH;

   // receiver holds off once, after this many accepted requests, for this many cycles
   localparam int HOLDOFF_AFTER  = 50;
   localparam int HOLDOFF_CYCLES = 5000;

   // pace of the result receiver
   typedef enum int {
      RX_STREAM,
      RX_COIN,
      RX_TRICKLE
   } rx_pace_type;

   // request transaction as it sits on req_tdata
   typedef struct packed {
      logic [FW-1:0] exponent;
      logic [FW-1:0] base_value;
   } power_request_type;

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_tvalid  = 1'b0;
   logic            req_tready;
   logic [2*FW-1:0] req_tdata   = '0;
   logic            rsp_tvalid;
   logic            rsp_tready  = 1'b0;
   logic [FW-1:0]   rsp_tdata;
   logic            csr_wr_en   = 1'b0;
   logic [FW-1:0]   csr_wr_data = '0;

   power_request_type pending_requests[$];
   logic [FW-1:0]   expected_powers[$];
   logic [FW-1:0]   active_modulus = mexp_pkg::MODULUS_RESET;
   logic            req_taken = 1'b0;
   int              power_requests_taken = 0;
   int              mismatch_count = 0;

   int              burst_left = 0;
   int              gap_left = 0;
   int              holdoff_left = 0;
   bit              holdoff_done = 1'b0;
   rx_pace_type     rx_pace = RX_STREAM;
   int              rx_pace_left = 0;

   modular_exponentiation_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // one modular reduction; a zero modulus keeps the low word
   function automatic logic [FW-1:0] reduce_word(logic [2*FW-1:0] product,
                                                  logic [FW-1:0] modulus);
      logic [2*FW-1:0] wide_mod;
      wide_mod = {{FW{1'b0}}, modulus};
      if (modulus == '0)
         return product[FW-1:0];
      return FW'(product % wide_mod);
   endfunction

   // right-to-left square-and-multiply, exponent zero gives 1 unreduced
   function automatic logic [FW-1:0] power_mod(logic [FW-1:0] base_value,
                                                logic [FW-1:0] exponent,
                                                logic [FW-1:0] modulus);
      logic [FW-1:0] acc;
      logic [FW-1:0] run_base;
      logic [FW-1:0] bits_left;
      acc = 1;
      run_base = base_value;
      bits_left = exponent;
      while (bits_left != '0) begin
         if (bits_left[0])
            acc = reduce_word({{FW{1'b0}}, acc} * {{FW{1'b0}}, run_base}, modulus);
         bits_left = bits_left >> 1;
         run_base = reduce_word({{FW{1'b0}}, run_base} * {{FW{1'b0}}, run_base}, modulus);
      end
      return acc;
   endfunction

   // sender: bursts of random length with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left != 0) begin
            req_tvalid <= 1'b0;
            gap_left--;
         end else if (pending_requests.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_requests.pop_front();
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 10);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: paced stalls plus one long hold-off to back the block up
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (!holdoff_done && power_requests_taken >= HOLDOFF_AFTER) begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoff_done = 1'b1;
         end
         if (rx_pace_left == 0) begin
            rx_pace = rx_pace_type'($urandom_range(0, 2));
            rx_pace_left = $urandom_range(16, 300);
         end else begin
            rx_pace_left--;
         end
         if (holdoff_left != 0) begin
            holdoff_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (rx_pace)
               RX_STREAM: rsp_tready <= 1'b1;
               RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               default:   rsp_tready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // monitor: check results against the oldest expected power, predict on accept
   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_powers.size() == 0) begin
            $error("unexpected power_result transaction: actual %08h", rsp_tdata);
            mismatch_count++;
         end else if (rsp_tdata !== expected_powers[0]) begin
            $error("power_result mismatch: expected %08h, actual %08h",
                   expected_powers[0], rsp_tdata);
            mismatch_count++;
            void'(expected_powers.pop_front());
         end else begin
            void'(expected_powers.pop_front());
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         expected_powers.push_back(power_mod(req_tdata[FW-1:0], req_tdata[2*FW-1:FW],
                                             active_modulus));
         power_requests_taken++;
      end
   end

   task automatic queue_power(input logic [FW-1:0] base_value, input logic [FW-1:0] exponent);
      power_request_type item;
      item.base_value = base_value;
      item.exponent = exponent;
      pending_requests.push_back(item);
   endtask

   // checked at the rising edge, where req_tvalid is settled
   task automatic wait_until_idle();
      while (pending_requests.size() != 0 || req_tvalid || expected_powers.size() != 0)
         @(posedge clock);
      repeat (10) @(negedge clock);
   endtask

   // modulus may only change with nothing in flight
   task automatic set_modulus(input logic [FW-1:0] value);
      wait_until_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      active_modulus = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_random_powers(input int count);
      logic [FW-1:0] base_value;
      logic [FW-1:0] exponent;
      int            width;
      int            pick;
      repeat (count) begin
         pick = $urandom_range(0, 9);
         if (pick == 0)
            base_value = $urandom_range(0, 3);
         else if (pick == 1)
            base_value = '1;
         else if (pick == 2)
            base_value = active_modulus - 1 + $urandom_range(0, 2);
         else
            base_value = $urandom();
         // mostly short exponents, a few full width ones
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            exponent = '0;
         end else if (pick < 95) begin
            width = (pick < 80) ? $urandom_range(1, 10) : $urandom_range(11, 20);
            exponent = ($urandom() >> (FW - width)) | (FW'(1) << (width - 1));
         end else begin
            exponent = $urandom() | {1'b1, {(FW-1){1'b0}}};
         end
         queue_power(base_value, exponent);
      end
   endtask

   // stimulus and end of test
   initial begin
      logic [FW-1:0] random_moduli[10];
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset modulus: zero exponent, zero base, full width operands, unreduced base
      queue_power(32'h0000_0000, 32'h0000_0000);
      queue_power(32'hFFFF_FFFF, 32'h0000_0000);
      queue_power(32'h0000_0000, 32'h0000_0005);
      queue_power(32'h0000_0001, 32'hFFFF_FFFF);
      queue_power(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_power(32'h0000_0002, 32'h0000_0001);
      queue_power(32'h0000_3001, 32'h0000_0003);
      queue_power(32'h0000_3002, 32'h0000_0007);
      queue_power(32'h0000_0003, 32'h0000_3000);
      queue_power(32'hDEAD_BEEF, 32'h8000_0000);
      queue_power(32'h0000_0005, 32'h5555_5555);

      // zero modulus works modulo the word size
      set_modulus(32'h0000_0000);
      queue_power(32'h0000_0003, 32'hFFFF_FFFF);
      queue_power(32'hFFFF_FFFF, 32'h0000_0002);
      queue_power(32'h0000_0007, 32'h0000_0000);

      // modulus one: zero exponent still gives 1, anything else 0
      set_modulus(32'h0000_0001);
      queue_power(32'h0000_0005, 32'h0000_0000);
      queue_power(32'h0000_0005, 32'h0000_0003);
      queue_power(32'h0000_0000, 32'h0000_0000);

      // smallest and largest legal moduli
      set_modulus(32'h0000_0002);
      queue_power(32'hFFFF_FFFF, 32'h0000_001F);
      queue_power(32'h0000_0004, 32'h0000_0001);
      set_modulus(32'hFFFF_FFFF);
      queue_power(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      queue_power(32'hFFFF_FFFF, 32'h0000_0001);

      // random phases over a spread of moduli
      random_moduli = '{32'd12289, 32'hFFFF_FFFF, 32'd2, 32'd0, 32'd3329, 32'd65537,
                        32'h8000_0000, 32'd0, 32'd0, 32'd1};
      random_moduli[7] = $urandom_range(2, 32'hFFFF_FFFF);
      random_moduli[8] = $urandom_range(2, 65535);
      foreach (random_moduli[i]) begin
         set_modulus(random_moduli[i]);
         queue_random_powers(50);
      end

      wait_until_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("modular_exponentiation_unit test passed");
      else
         $display("modular_exponentiation_unit test failed");
      $finish;
   end

   // generous bound on the slowest legal run, full width exponents everywhere
   initial begin
      #100_000_000;
      $display("modular_exponentiation_unit test failed");
      $finish;
   end

endmodule

### files.f
design/mexp_pkg.sv
design/mexp_mulmod.sv
design/modular_exponentiation_unit.sv
verif/tb_modular_exponentiation_unit.sv
